/* rtl/core/tetm_pkg.sv */
// Shared types, register codes and curve-building functions for the timing error tone mapper.
`timescale 1ns / 1ps

package tetm_pkg;

    // Field widths
    localparam int ERR_W   = 18;
    localparam int DIST_W  = 20;
    localparam int FREQ_W  = 12;
    localparam int CFG_W   = 17;
    localparam int CIDX_W  = 2;

    // Register reset values
    localparam logic [15:0] QUIET_BAND_RST = 16'd200;
    localparam logic [15:0] UPD_THR_RST    = 16'd200;
    localparam logic [16:0] MAX_ERR_RST    = 17'd30000;
    localparam logic [15:0] MIN_DIST_RST   = 16'd250;

    // Curve end points: behind 1800 Hz times 35/18, ahead 800 Hz times 2
    localparam logic [127:0] BEHIND_MIN_HZ = 128'd1800;
    localparam logic [127:0] AHEAD_MIN_HZ  = 128'd800;
    // ln r = 2*atanh(P/Q) with P/Q = (r-1)/(r+1)
    localparam logic [127:0] LN_BEHIND_P   = 128'd17;
    localparam logic [127:0] LN_BEHIND_Q   = 128'd53;
    localparam logic [127:0] LN_AHEAD_P    = 128'd1;
    localparam logic [127:0] LN_AHEAD_Q    = 128'd3;
    localparam int           LN_TERMS      = 40;
    localparam int           EXP_TERMS     = 30;
    localparam logic [127:0] Q60_ONE       = 128'd1 << 60;

    typedef enum logic [CIDX_W-1:0] {
        CFG_QUIET_BAND = 2'd0,
        CFG_UPD_THR    = 2'd1,
        CFG_MAX_ERR    = 2'd2,
        CFG_MIN_DIST   = 2'd3
    } t_cfg_idx;

    typedef logic signed [ERR_W-1:0] t_err;
    typedef logic [FREQ_W-1:0]       t_freq;

    typedef struct packed {
        logic [15:0] quiet_band_ms;
        logic [15:0] update_threshold_ms;
        logic [16:0] max_error_ms;
        logic [15:0] stage_floor_m;
    } t_cfg;

    typedef struct packed {
        logic sound;
        logic behind;
    } t_tone_ctl;

    // ln of the side's pitch ratio in Q60, atanh series with truncating steps
    function automatic logic [127:0] ln_ratio_q60(input logic behind);
        logic [127:0] pw;
        logic [127:0] sum;
        if (behind) begin
            pw = (Q60_ONE / LN_BEHIND_Q) * LN_BEHIND_P
               + ((Q60_ONE % LN_BEHIND_Q) * LN_BEHIND_P) / LN_BEHIND_Q;
        end else begin
            pw = (Q60_ONE / LN_AHEAD_Q) * LN_AHEAD_P
               + ((Q60_ONE % LN_AHEAD_Q) * LN_AHEAD_P) / LN_AHEAD_Q;
        end
        sum = '0;
        for (int k = 0; k < LN_TERMS; k++) begin
            sum = sum + pw / 128'(2 * k + 1);
            if (behind) begin
                pw = pw * LN_BEHIND_P / LN_BEHIND_Q;
                pw = pw * LN_BEHIND_P / LN_BEHIND_Q;
            end else begin
                pw = pw * LN_AHEAD_P / LN_AHEAD_Q;
                pw = pw * LN_AHEAD_P / LN_AHEAD_Q;
            end
        end
        return sum << 1;
    endfunction

    // e^u in Q60, Taylor sum with floored products
    function automatic logic [127:0] exp_q60(input logic [127:0] u);
        logic [127:0] sum;
        logic [127:0] term;
        sum  = Q60_ONE;
        term = Q60_ONE;
        for (int k = 1; k <= EXP_TERMS; k++) begin
            term = ((term * u) >> 60) / 128'(k);
            sum  = sum + term;
        end
        return sum;
    endfunction

endpackage

/* rtl/core/tetm_latch.sv */
// Tone zone check, latched error update and curve index for one word.
`timescale 1ns / 1ps

module tetm_latch
    import tetm_pkg::*;
#(
    parameter int RAMP_END_MS = 3000,
    parameter int CURVE_STEPS = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_fire,
    input  t_cfg                             i_cfg,
    input  t_err                             i_error_ms,
    input  logic [DIST_W-1:0]                i_stage_distance_m,
    input  logic                             i_past_stage_end,
    output t_tone_ctl                        o_ctl,
    output logic [$clog2(CURVE_STEPS+1)-1:0] o_j
);

    localparam int M_W      = $clog2(RAMP_END_MS + 1);
    localparam int J_W      = $clog2(CURVE_STEPS + 1);
    // reciprocal of the ramp length, exact for every clamped magnitude
    localparam int RECIP_SH = 2 * $clog2(RAMP_END_MS);
    localparam longint unsigned RECIP =
        ((64'(CURVE_STEPS) << RECIP_SH) + 64'(RAMP_END_MS) - 64'd1) / 64'(RAMP_END_MS);
    localparam int C_W      = $clog2(RECIP + 1);
    localparam int P_W      = M_W + C_W;

    logic [ERR_W-1:0] r_committed;
    logic [ERR_W-1:0] n_committed;

    logic [ERR_W-1:0] err_u;
    logic [ERR_W-1:0] err_mag;
    logic [ERR_W:0]   diff;
    logic [ERR_W:0]   diff_mag;
    logic [ERR_W-1:0] lat_mag;
    logic             in_zone;
    logic             quiet;
    logic             give_up;
    logic [M_W-1:0]   m;
    logic [P_W-1:0]   prod;

    function automatic logic [ERR_W-1:0] err_mag_src(input t_err e);
        return ERR_W'(unsigned'(e));
    endfunction

    // decide zone, quiet band and latch move
    always_comb begin
        err_u    = err_mag_src(i_error_ms);
        err_mag  = i_error_ms[ERR_W-1] ? (~err_u + 1'b1) : err_u;
        diff     = {i_error_ms[ERR_W-1], i_error_ms} - {r_committed[ERR_W-1], r_committed};
        diff_mag = diff[ERR_W] ? (~diff + 1'b1) : diff;
        in_zone  = !((i_stage_distance_m < DIST_W'(i_cfg.stage_floor_m))
                     || i_past_stage_end);
        quiet    = err_mag < ERR_W'(i_cfg.quiet_band_ms);
        if (!in_zone) begin
            n_committed = '0;
        end else if (quiet || (diff_mag > (ERR_W + 1)'(i_cfg.update_threshold_ms))) begin
            n_committed = err_u;
        end else begin
            n_committed = r_committed;
        end
        lat_mag = n_committed[ERR_W-1] ? (~n_committed + 1'b1) : n_committed;
        give_up = lat_mag > ERR_W'(i_cfg.max_error_ms);
    end

    // scale the clamped magnitude onto the curve index and set the tone control
    always_comb begin
        if (lat_mag > ERR_W'(RAMP_END_MS)) begin
            m = M_W'(RAMP_END_MS);
        end else begin
            m = lat_mag[M_W-1:0];
        end
        prod         = P_W'(m) * P_W'(RECIP);
        o_j          = J_W'(prod >> RECIP_SH);
        o_ctl.sound  = in_zone && !quiet && !give_up;
        o_ctl.behind = n_committed[ERR_W-1];
    end

    // hold the latched error between words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_committed <= '0;
        end else if (i_fire) begin
            r_committed <= n_committed;
        end
    end

    a_zone_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !in_zone |=> r_committed == '0)
        else $error("latch not cleared outside the tone zone");

endmodule

/* rtl/core/tetm_tone_rom.sv */
// Per-side pitch curve tables with registered read, forming the result register.
`timescale 1ns / 1ps

module tetm_tone_rom
    import tetm_pkg::*;
#(
    parameter int CURVE_STEPS = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  t_tone_ctl                        i_ctl,
    input  logic [$clog2(CURVE_STEPS+1)-1:0] i_j,
    output logic                             o_sounding,
    output t_freq                            o_freq_hz,
    output logic                             o_triangle_wave
);

    typedef logic [CURVE_STEPS:0][FREQ_W-1:0] t_rom;

    // round(min_hz * r^(j/steps)) for every index, Q40 cut then half-up rounding
    function automatic t_rom build_rom(input logic behind);
        t_rom         rom;
        logic [127:0] lnr;
        logic [127:0] qd;
        logic [127:0] rm;
        logic [127:0] u;
        logic [127:0] v;
        logic [127:0] min_hz;
        lnr    = ln_ratio_q60(behind);
        qd     = lnr / CURVE_STEPS;
        rm     = lnr % CURVE_STEPS;
        min_hz = behind ? BEHIND_MIN_HZ : AHEAD_MIN_HZ;
        for (int jj = 0; jj <= CURVE_STEPS; jj++) begin
            u       = qd * 128'(jj) + (rm * 128'(jj)) / CURVE_STEPS;
            v       = (exp_q60(u) >> 20) * min_hz;
            rom[jj] = FREQ_W'((v + (128'd1 << 39)) >> 40);
        end
        return rom;
    endfunction

    localparam t_rom ROM_BEHIND = build_rom(1'b1);
    localparam t_rom ROM_AHEAD  = build_rom(1'b0);

    logic  r_sounding;
    logic  r_triangle;
    t_freq r_freq;

    // read the side's table, zero the word when silent
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sounding <= i_ctl.sound;
            r_triangle <= i_ctl.sound && i_ctl.behind;
            if (!i_ctl.sound) begin
                r_freq <= '0;
            end else if (i_ctl.behind) begin
                r_freq <= ROM_BEHIND[i_j];
            end else begin
                r_freq <= ROM_AHEAD[i_j];
            end
        end
    end

    assign o_sounding      = r_sounding;
    assign o_freq_hz       = r_freq;
    assign o_triangle_wave = r_triangle;

    a_silent_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load && !i_ctl.sound |=> (o_freq_hz == '0) && !o_triangle_wave && !o_sounding)
        else $error("silent word carries a tone");

endmodule

/* rtl/core/timing_error_tone_mapper.sv */
// Top level of the timing error tone mapper: handshake, registers and the two stages.
`timescale 1ns / 1ps

//  channel  | dir | handshake                      | payload
//  ---------+-----+--------------------------------+----------------------------------------
//  in       | in  | i_in_valid / o_in_ready        | i_error_ms, i_stage_distance_m,
//           |     |                                | i_past_stage_end
//  out      | out | o_out_valid / i_out_ready      | o_sounding, o_freq_hz, o_triangle_wave
//  cfg      | in  | i_cfg_we (no wait)             | i_cfg_idx, i_cfg_data
//
//  One word per cycle sustained unless the output stalls; a result is valid once its word has
//  passed an input register, then the latch and index logic feeding the registered curve read.
//  The latched error updates as a word leaves the input register, so words chain back to back.
//  Synchronous reset clears both stage valid flags and the latch, and loads register defaults.
//  A stall on the output holds both stages; the input register still fills while one is free.

module timing_error_tone_mapper
    import tetm_pkg::*;
#(
    parameter int RAMP_END_MS = 3000,
    parameter int CURVE_STEPS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_err              i_error_ms,
    input  logic [DIST_W-1:0] i_stage_distance_m,
    input  logic              i_past_stage_end,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_sounding,
    output t_freq             o_freq_hz,
    output logic              o_triangle_wave,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    localparam int J_W = $clog2(CURVE_STEPS + 1);

    t_cfg              r_cfg;
    logic              r_in_v;
    logic              r_out_v;
    t_err              r_err;
    logic [DIST_W-1:0] r_dist;
    logic              r_past;

    logic              adv_out;
    logic              s1_fire;
    logic              in_fire;
    t_tone_ctl         ctl;
    logic [J_W-1:0]    j;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quiet_band_ms       <= QUIET_BAND_RST;
            r_cfg.update_threshold_ms <= UPD_THR_RST;
            r_cfg.max_error_ms        <= MAX_ERR_RST;
            r_cfg.stage_floor_m       <= MIN_DIST_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_QUIET_BAND: r_cfg.quiet_band_ms       <= i_cfg_data[15:0];
                CFG_UPD_THR:    r_cfg.update_threshold_ms <= i_cfg_data[15:0];
                CFG_MAX_ERR:    r_cfg.max_error_ms        <= i_cfg_data[16:0];
                CFG_MIN_DIST:   r_cfg.stage_floor_m       <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // advance stages when the next one is free
    assign adv_out     = !r_out_v || i_out_ready;
    assign s1_fire     = r_in_v && adv_out;
    assign o_in_ready  = !r_in_v || adv_out;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (in_fire) begin
                r_in_v <= 1'b1;
            end else if (s1_fire) begin
                r_in_v <= 1'b0;
            end
            if (s1_fire) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // capture the input word
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_err  <= i_error_ms;
            r_dist <= i_stage_distance_m;
            r_past <= i_past_stage_end;
        end
    end

    tetm_latch #(
        .RAMP_END_MS (RAMP_END_MS),
        .CURVE_STEPS (CURVE_STEPS)
    ) u_latch (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_fire             (s1_fire),
        .i_cfg              (r_cfg),
        .i_error_ms         (r_err),
        .i_stage_distance_m (r_dist),
        .i_past_stage_end   (r_past),
        .o_ctl              (ctl),
        .o_j                (j)
    );

    tetm_tone_rom #(
        .CURVE_STEPS (CURVE_STEPS)
    ) u_rom (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (s1_fire),
        .i_ctl           (ctl),
        .i_j             (j),
        .o_sounding      (o_sounding),
        .o_freq_hz       (o_freq_hz),
        .o_triangle_wave (o_triangle_wave)
    );

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_in_v)
        else $error("accepted word not held in the input register");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_v && !adv_out |=> r_in_v && $stable(r_err) && $stable(r_dist))
        else $error("stalled input register changed");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> o_out_valid)
        else $error("word left the input register without a result");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the timing error tone mapper: random and directed words.
`timescale 1ns / 1ps

module tb_top;
    import tetm_pkg::*;

    localparam int RAMP_MS     = 3000;
    localparam int CURVE_PTS   = 256;
    localparam int PIPE_DEPTH  = 2;
    localparam int CYCLE_LIMIT = 100000;
    localparam int REPORT_MAX  = 10;
    localparam logic [127:0] Q60 = 128'd1 << 60;

    typedef struct packed {
        logic  sounding;
        t_freq freq_hz;
        logic  triangle;
    } tone_word_t;

    // Predict each tone word from the accepted input words and check the output words
    class tone_scoreboard;
        int quiet_band;
        int update_thr;
        int max_err;
        int min_dist;
        int latch_err;
        int mismatches;
        t_freq curve_behind[CURVE_PTS + 1];
        t_freq curve_ahead[CURVE_PTS + 1];
        tone_word_t expected_tones[$];

        function new();
            logic [127:0] ln_behind;
            logic [127:0] ln_ahead;
            int j;
            quiet_band = QUIET_BAND_RST;
            update_thr = UPD_THR_RST;
            max_err    = MAX_ERR_RST;
            min_dist   = MIN_DIST_RST;
            latch_err  = 0;
            mismatches = 0;
            // Build both pitch curves: behind 1800 Hz up by 35/18, ahead 800 Hz up by 2
            ln_behind = log_ratio(128'd17, 128'd53);
            ln_ahead  = log_ratio(128'd1, 128'd3);
            for (j = 0; j <= CURVE_PTS; j++) begin
                curve_behind[j] = curve_point(128'd1800, ln_behind, j);
                curve_ahead[j]  = curve_point(128'd800, ln_ahead, j);
            end
        endfunction

        // ln((q+p)/(q-p)) in Q60 as twice the atanh series of p/q, truncating each step
        function logic [127:0] log_ratio(logic [127:0] p, logic [127:0] q);
            logic [127:0] pw;
            logic [127:0] acc;
            int k;
            pw  = (Q60 * p) / q;
            acc = '0;
            for (k = 0; k < 40; k++) begin
                acc = acc + pw / 128'(2 * k + 1);
                pw  = (pw * p) / q;
                pw  = (pw * p) / q;
            end
            return acc << 1;
        endfunction

        // Curve entry: min_hz * e^(ln_r * j / steps), Taylor sum in Q60, rounded to whole Hz
        function t_freq curve_point(logic [127:0] min_hz, logic [127:0] ln_r, int j);
            logic [127:0] u;
            logic [127:0] term;
            logic [127:0] acc;
            logic [127:0] scaled;
            int k;
            u    = (ln_r * 128'(j)) / 128'(CURVE_PTS);
            term = Q60;
            acc  = Q60;
            for (k = 1; k <= 30; k++) begin
                term = ((term * u) >> 60) / 128'(k);
                acc  = acc + term;
            end
            scaled = (acc >> 20) * min_hz;
            return t_freq'((scaled + (128'd1 << 39)) >> 40);
        endfunction

        function int magnitude(int v);
            return (v < 0) ? -v : v;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_QUIET_BAND: quiet_band = data[15:0];
                CFG_UPD_THR:    update_thr = data[15:0];
                CFG_MAX_ERR:    max_err    = data;
                CFG_MIN_DIST:   min_dist   = data[15:0];
                default: ;
            endcase
        endfunction

        // Advance the latch with one input word and queue the tone it gives
        function void note_input(t_err err, logic [DIST_W-1:0] stage_m, logic past);
            tone_word_t w;
            int e;
            int mag;
            int j;
            e = err;
            w = '0;
            if (int'(stage_m) < min_dist || past) begin
                latch_err = 0;
            end else if (magnitude(e) < quiet_band) begin
                latch_err = e;
            end else begin
                if (magnitude(e - latch_err) > update_thr) latch_err = e;
                mag = magnitude(latch_err);
                if (mag <= max_err) begin
                    if (mag > RAMP_MS) mag = RAMP_MS;
                    j = mag * CURVE_PTS / RAMP_MS;
                    w.sounding = 1'b1;
                    w.triangle = (latch_err < 0);
                    w.freq_hz  = (latch_err < 0) ? curve_behind[j] : curve_ahead[j];
                end
            end
            expected_tones.push_back(w);
        endfunction

        // Compare one output word against the oldest queued tone
        function void check_result(logic sounding, t_freq freq_hz, logic triangle);
            tone_word_t got;
            tone_word_t want;
            got.sounding = sounding;
            got.freq_hz  = freq_hz;
            got.triangle = triangle;
            if (expected_tones.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected output word: sounding=%0b freq=%0d triangle=%0b",
                             sounding, freq_hz, triangle);
            end else begin
                want = expected_tones.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("mismatch: expected sounding=%0b freq=%0d triangle=%0b, %s",
                                 want.sounding, want.freq_hz, want.triangle,
                                 $sformatf("got sounding=%0b freq=%0d triangle=%0b",
                                           sounding, freq_hz, triangle));
                end
            end
        endfunction

        function int pending();
            return expected_tones.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_err              i_error_ms;
    logic [DIST_W-1:0] i_stage_distance_m;
    logic              i_past_stage_end;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_sounding;
    t_freq             o_freq_hz;
    logic              o_triangle_wave;
    logic              i_cfg_we;
    logic [CIDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;

    tone_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count = 0;

    timing_error_tone_mapper #(
        .RAMP_END_MS(RAMP_MS),
        .CURVE_STEPS(CURVE_PTS)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_error_ms        (i_error_ms),
        .i_stage_distance_m(i_stage_distance_m),
        .i_past_stage_end  (i_past_stage_end),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_sounding        (o_sounding),
        .o_freq_hz         (o_freq_hz),
        .o_triangle_wave   (o_triangle_wave),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Stall the output side at random
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check every accepted output word
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_sounding, o_freq_hz, o_triangle_wave);
    end

    // Drop the run if it hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one input word after a random gap and hold it until accepted
    task automatic send_word(int err, int stage_m, logic past);
        int gap;
        t_err err_w;
        logic [DIST_W-1:0] stage_w;
        err_w   = t_err'(err);
        stage_w = DIST_W'(stage_m);
        gap     = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_error_ms         <= err_w;
        i_stage_distance_m <= stage_w;
        i_past_stage_end   <= past;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(err_w, stage_w, past);
    endtask

    // Hold off input until every queued tone has come out
    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
    endtask

    // Drain the pipe, then load all four registers
    task automatic configure(int quiet, int thr, int max_e, int min_m);
        wait_for_results();
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
        write_reg(CFG_QUIET_BAND, CFG_W'(quiet));
        write_reg(CFG_UPD_THR, CFG_W'(thr));
        write_reg(CFG_MAX_ERR, CFG_W'(max_e));
        write_reg(CFG_MIN_DIST, CFG_W'(min_m));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // 16-bit register value: zero, all ones, or small, with a random spare top bit
    function automatic logic [CFG_W-1:0] pick_reg16(int span);
        logic [CFG_W-1:0] v;
        case ($urandom_range(5))
            0: v = '0;
            1: v = '1;
            default: begin
                v     = CFG_W'($urandom_range(span));
                v[16] = $urandom_range(1);
            end
        endcase
        return v;
    endfunction

    initial begin
        int phase;
        int n;
        int r;
        int e;
        int sgn;
        int near;
        int stage_m;
        logic past;
        logic [CFG_W-1:0] max_e;
        logic [CFG_W-1:0] min_d;

        sb                 = new();
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_error_ms         = '0;
        i_stage_distance_m = '0;
        i_past_stage_end   = 1'b0;
        i_out_ready        = 1'b1;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_QUIET_BAND;
        i_cfg_data         = '0;
        send_idle_pct      = 10;
        recv_idle_pct      = 78;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default settings: zone edges, quiet band and threshold edges, ramp end, give-up limit
        send_word(0, 0, 1'b0);
        send_word(131071, 20'hFFFFF, 1'b1);
        send_word(-131072, 249, 1'b0);
        send_word(-131072, 250, 1'b0);
        send_word(131071, 20'hFFFFF, 1'b0);
        send_word(199, 1000, 1'b0);
        send_word(200, 1000, 1'b0);
        send_word(400, 1000, 1'b0);
        send_word(-199, 1000, 1'b0);
        send_word(-3000, 1000, 1'b0);
        send_word(-2999, 1000, 1'b0);
        send_word(3000, 1000, 1'b0);
        send_word(30000, 1000, 1'b0);
        send_word(30001, 1000, 1'b0);
        send_word(30500, 1000, 1'b0);

        // No quiet band: zero latch sounds ahead, latch sign opposite to the error
        configure(0, 400, '1, 0);
        send_word(0, 0, 1'b0);
        send_word(-300, 0, 1'b0);
        send_word(-131072, 5, 1'b0);
        send_word(131071, 5, 1'b0);
        send_word(-350, 7, 1'b0);
        send_word(50, 7, 1'b0);
        send_word(131071, 7, 1'b1);

        // All registers at their top, give-up limit at zero
        configure('1, '1, 0, '1);
        send_word(-65534, 65535, 1'b0);
        send_word(65535, 65534, 1'b0);
        send_word(65535, 65535, 1'b0);
        send_word(-131072, 20'hFFFFF, 1'b0);

        // Random phases, mostly near the thresholds of the current settings
        for (phase = 0; phase < 9; phase++) begin
            if (phase == 3) begin
                send_idle_pct = 78;
                recv_idle_pct = 10;
            end
            if (phase == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(5))
                0: max_e = '0;
                1: max_e = '1;
                default: max_e = CFG_W'($urandom_range(40000));
            endcase
            case ($urandom_range(5))
                0: min_d = '0;
                1: min_d = '1;
                default: min_d = CFG_W'($urandom_range(2000));
            endcase
            configure(pick_reg16(1500), pick_reg16(1500), max_e, min_d);

            for (n = 0; n < 72; n++) begin
                if (n == 36) wait_for_results();
                r = $urandom_range(99);
                if (r < 8 && sb.min_dist > 0)
                    stage_m = $urandom_range(sb.min_dist - 1);
                else if (r < 16)
                    stage_m = $urandom_range(20'hFFFFF);
                else
                    stage_m = sb.min_dist + int'($urandom_range(5000));
                past = ($urandom_range(99) < 6);
                sgn  = $urandom_range(1) ? 1 : -1;
                near = int'($urandom_range(6)) - 3;
                r    = $urandom_range(99);
                if (r < 25)
                    e = sb.latch_err + int'($urandom_range(2 * sb.update_thr + 100))
                        - (sb.update_thr + 50);
                else if (r < 40)
                    e = sgn * (sb.quiet_band + near);
                else if (r < 55)
                    e = sgn * (sb.max_err + near);
                else if (r < 65)
                    e = sgn * (RAMP_MS + near);
                else if (r < 85)
                    e = int'($urandom_range(8000)) - 4000;
                else
                    e = int'(t_err'($urandom));
                // Saturate to the field range
                if (e > 131071) e = 131071;
                if (e < -131072) e = -131072;
                send_word(e, stage_m, past);
            end
        end

        // Let the last words drain, then report
        wait_for_results();
        repeat (PIPE_DEPTH * 4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
